// ===== design/aia_pkg.sv =====
package aia_pkg;

	// accumulator width used when none is given
	localparam int DATA_WIDTH_DEF = 32;

	// stream field widths
	localparam int OPERATION_W = 3;
	localparam int OPERAND_W   = 32;
	localparam int VALUE_W     = 32;
	localparam int SIGBITS_W   = 6;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 80;

	// bit-count tree: leaf group size
	localparam int GROUP_W = 8;

	typedef enum logic [OPERATION_W-1:0] {
		OP_LOAD = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_SHL  = 3'd5,
		OP_SHR  = 3'd6,
		OP_CMP  = 3'd7
	} op_t;

endpackage

// ===== design/aia_addsub.sv =====
module aia_addsub #(
	parameter int DATA_WIDTH = aia_pkg::DATA_WIDTH_DEF
) (
	input  logic [DATA_WIDTH:0] a,
	input  logic [DATA_WIDTH:0] b,
	input  logic                sub,
	output logic [DATA_WIDTH:0] sum
);
	import aia_pkg::*;

	// one adder shared by add, subtract, multiply steps and divide steps
	assign sum = a + (b ^ {(DATA_WIDTH + 1){sub}}) + (DATA_WIDTH + 1)'(sub);

endmodule

// ===== design/aia_sigbits.sv =====
module aia_sigbits #(
	parameter int DATA_WIDTH = aia_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              load,
	input  logic [DATA_WIDTH-1:0]             value,
	output logic [$clog2(DATA_WIDTH + 1)-1:0] count
);
	import aia_pkg::*;

	localparam int GROUPS = (DATA_WIDTH + GROUP_W - 1) / GROUP_W;
	localparam int PAD_W  = GROUPS * GROUP_W;
	localparam int POS_W  = $clog2(GROUP_W);
	localparam int CNT_W  = $clog2(DATA_WIDTH + 1);

	logic [PAD_W-1:0] padded;
	logic [GROUPS-1:0] nz_s1;
	logic [POS_W-1:0] pos_s1 [GROUPS];
	logic [GROUPS-1:0] nz_d;
	logic [POS_W-1:0] pos_d [GROUPS];

	assign padded = PAD_W'(value);

	// first level: highest set bit inside each group
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			nz_d[g]  = |padded[g*GROUP_W +: GROUP_W];
			pos_d[g] = '0;
			for (int i = 0; i < GROUP_W; i++) begin
				if (padded[g*GROUP_W + i]) begin
					pos_d[g] = POS_W'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nz_s1 <= nz_d;
			for (int g = 0; g < GROUPS; g++) begin
				pos_s1[g] <= pos_d[g];
			end
		end
	end

	// second level: pick the highest nonzero group
	always_comb begin
		count = '0;
		for (int g = 0; g < GROUPS; g++) begin
			if (nz_s1[g]) begin
				count = CNT_W'(g * GROUP_W) + CNT_W'(pos_s1[g]) + CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/accumulator_integer_alu.sv =====
// Accumulator ALU with one shared adder.
// Input stream (s_axis_*): each beat carries an operation and an operand; the
// beat updates the internal accumulator (load, add, sub, mul, div, shift left,
// shift right, compare). Output stream (m_axis_*): exactly one beat per input
// beat, in order, with the new accumulator, the division remainder and flags.
// Each accepted beat passes through the sequencer states in order: an execute
// step for load, add, sub, shifts, compare and divide by zero, or the iteration
// for multiply and nonzero divide; then the registered bit-count tree; then the
// result handoff. In the iteration the shared adder does one shift-add or one
// restoring-divide step per cycle.
// s_axis_tready is high only while the sequencer is idle; one beat is in work at
// a time. Results sit in an output register, so a new beat is taken while the
// previous result still waits; if that result is still not taken when the next
// one is ready, the sequencer holds until m_axis_tready frees the register.
// Reset (arst_n low) clears the accumulator to zero and drops any pending beat.
module accumulator_integer_alu #(
	parameter int DATA_WIDTH = aia_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// operation [2:0], operand [34:3], zero [39:35]
	input  logic [aia_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// value [31:0], remainder [63:32], greater [64], equal [65], is_zero [66],
	// is_negative [67], significant_bits [73:68], divide_by_zero [74], zero [79:75]
	output logic [aia_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import aia_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam int SIG_W = $clog2(DATA_WIDTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_ITER = 5'b00100,
		S_SIG  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	typedef struct packed {
		logic                 divide_by_zero;
		logic [SIGBITS_W-1:0] significant_bits;
		logic                 is_negative;
		logic                 is_zero;
		logic                 equal;
		logic                 greater;
		logic [VALUE_W-1:0]   remainder;
		logic [VALUE_W-1:0]   value;
	} result_t;

	// control
	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [DATA_WIDTH-1:0] acc_q;

	// working registers of the current beat
	op_t                   op_q;
	logic [DATA_WIDTH-1:0] y_q;   // operand; multiplier shifts right, divisor holds
	logic [DATA_WIDTH-1:0] x_q;   // multiplicand shifts left / dividend becomes quotient
	logic [DATA_WIDTH-1:0] r_q;   // partial product / partial remainder
	logic                  gt_q;
	logic                  eq_q;
	logic                  dz_q;
	result_t               res_q;

	op_t                   in_op;
	logic [DATA_WIDTH-1:0] in_operand;
	logic                  in_fire;
	logic                  out_free;
	logic                  res_load;
	logic                  last_step;

	logic [DATA_WIDTH:0]   add_a;
	logic [DATA_WIDTH:0]   add_b;
	logic                  add_sub;
	logic [DATA_WIDTH:0]   add_sum;

	logic [CNT_W-1:0]      shamt;
	logic [DATA_WIDTH-1:0] exec_next;
	logic [DATA_WIDTH-1:0] mul_r_next;
	logic                  div_borrow;
	logic [DATA_WIDTH-1:0] div_r_next;
	logic [DATA_WIDTH-1:0] div_q_next;
	logic [SIG_W-1:0]      sig_count;

	assign in_op      = op_t'(s_axis_tdata[OPERATION_W-1:0]);
	assign in_operand = DATA_WIDTH'(s_axis_tdata[OPERATION_W +: OPERAND_W]);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	// hand the finished beat to the output register
	assign res_load      = (state_q == S_DONE) && out_free;
	assign last_step     = (cnt_q == CNT_W'(DATA_WIDTH - 1));

	// steer the shared adder: execute uses acc/operand, iterations use the work regs
	always_comb begin
		add_a   = {1'b0, acc_q};
		add_b   = {1'b0, y_q};
		add_sub = (op_q == OP_SUB);
		if (state_q == S_ITER) begin
			if (op_q == OP_MUL) begin
				add_a   = {1'b0, r_q};
				add_b   = {1'b0, x_q};
				add_sub = 1'b0;
			end else begin
				// trial subtract of the divisor from the shifted partial remainder
				add_a   = {r_q, x_q[DATA_WIDTH-1]};
				add_b   = {1'b0, y_q};
				add_sub = 1'b1;
			end
		end
	end

	aia_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_addsub (
		.a   (add_a),
		.b   (add_b),
		.sub (add_sub),
		.sum (add_sum)
	);

	// multiply step: add the shifted multiplicand when the multiplier bit is set
	assign mul_r_next = y_q[0] ? add_sum[DATA_WIDTH-1:0] : r_q;

	// divide step: restore on borrow, shift the quotient bit in
	assign div_borrow = add_sum[DATA_WIDTH];
	assign div_r_next = div_borrow ? add_a[DATA_WIDTH-1:0] : add_sum[DATA_WIDTH-1:0];
	assign div_q_next = {x_q[DATA_WIDTH-2:0], !div_borrow};

	// saturate the shift count at DATA_WIDTH-1
	assign shamt = (y_q > DATA_WIDTH'(DATA_WIDTH - 1)) ? CNT_W'(DATA_WIDTH - 1)
	                                                   : y_q[CNT_W-1:0];

	always_comb begin
		case (op_q)
			OP_LOAD: exec_next = y_q;
			OP_ADD:  exec_next = add_sum[DATA_WIDTH-1:0];
			OP_SUB:  exec_next = add_sum[DATA_WIDTH-1:0];
			OP_SHL:  exec_next = acc_q << shamt;
			OP_SHR:  exec_next = acc_q >> shamt;
			default: exec_next = acc_q;   // compare and divide by zero keep the value
		endcase
	end

	aia_sigbits #(.DATA_WIDTH(DATA_WIDTH)) u_sigbits (
		.clk   (clk),
		.load  (state_q == S_SIG),
		.value (acc_q),
		.count (sig_count)
	);

	// sequencer and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a handoff, drop it once the held beat is taken
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						// multiply and nonzero divide iterate; everything else is one step
						if (in_op == OP_MUL || (in_op == OP_DIV && in_operand != '0)) begin
							state_q <= S_ITER;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					acc_q   <= exec_next;
					state_q <= S_SIG;
				end
				S_ITER: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_step) begin
						acc_q   <= (op_q == OP_MUL) ? mul_r_next : div_q_next;
						state_q <= S_SIG;
					end
				end
				S_SIG: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold here until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q <= in_op;
					y_q  <= in_operand;
					x_q  <= acc_q;
					r_q  <= '0;
					gt_q <= (acc_q > in_operand);
					eq_q <= (acc_q == in_operand);
					dz_q <= 1'b0;
				end
			end
			S_EXEC: begin
				dz_q <= (op_q == OP_DIV);
			end
			S_ITER: begin
				if (op_q == OP_MUL) begin
					r_q <= mul_r_next;
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end else begin
					r_q <= div_r_next;
					x_q <= div_q_next;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_q.value            <= VALUE_W'(acc_q);
					res_q.remainder        <= (op_q == OP_DIV && !dz_q) ? VALUE_W'(r_q)
					                                                   : '0;
					res_q.greater          <= gt_q;
					res_q.equal            <= eq_q;
					res_q.is_zero          <= (acc_q == '0);
					res_q.is_negative      <= acc_q[DATA_WIDTH-1];
					res_q.significant_bits <= SIGBITS_W'(sig_count);
					res_q.divide_by_zero   <= dz_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(res_q);

	// one beat in work at a time: ready drops right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("input accepted while a beat is in work");

	// a result appears only out of the handoff state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside handoff");

	// compare and divide by zero leave the accumulator untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && (op_q == OP_CMP || op_q == OP_DIV)) |=> $stable(acc_q))
		else $error("accumulator changed on compare or divide by zero");

	// the iteration runs its full count before leaving
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && !last_step) |=> (state_q == S_ITER))
		else $error("iteration ended early");

endmodule
